>>> sv/cubic_varispeed_resampler_macros.svh
// assertion macros for the cubic varispeed resampler checker
`ifndef CUBIC_VARISPEED_RESAMPLER_MACROS_SVH
`define CUBIC_VARISPEED_RESAMPLER_MACROS_SVH

// same-cycle implication, reset disables
`define CVR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset disables
`define CVR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/cvr_pkg.sv
// shared constants, codes and control structs of the cubic varispeed resampler
`default_nettype none
package cvr_pkg;

	localparam int TRACK_DEPTH_DEF = 65536;
	localparam int MAX_BLOCK_DEF   = 4096;

	localparam int RATE_W   = 18;
	localparam int FRAMES_W = 17;
	localparam int CFG_W    = 18;
	localparam logic [RATE_W-1:0] RATE_RESET = 18'd65536;

	// register indexes
	localparam logic REG_RATE_RATIO   = 1'b0;
	localparam logic REG_TRACK_FRAMES = 1'b1;

	// opcodes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// divider user
	localparam logic [1:0] DIV_PITCH = 2'd0;
	localparam logic [1:0] DIV_GAIN  = 2'd1;
	localparam logic [1:0] DIV_MOD   = 2'd2;

	// multiply-accumulate step
	localparam logic [2:0] MAC_IDLE = 3'd0;
	localparam logic [2:0] MAC_C1   = 3'd1;
	localparam logic [2:0] MAC_C2   = 3'd2;
	localparam logic [2:0] MAC_C3   = 3'd3;
	localparam logic [2:0] MAC_VOL  = 3'd4;

	localparam int DIVD_W = 32;
	localparam int DIVS_W = 17;

	typedef struct packed {
		logic       load;
		logic       div_go;
		logic [1:0] div_sel;
		logic       div_cap;
		logic       first_cap;
		logic       rd_en;
		logic [1:0] rd_tap;
		logic       tap_cap;
		logic [1:0] cap_idx;
		logic [2:0] mac_op;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic mod_skip;
		logic cnt_zero;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

>>> sv/cvr_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module cvr_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        go,
	input  wire logic [cvr_pkg::DIVD_W-1:0]  dividend,
	input  wire logic [cvr_pkg::DIVS_W-1:0]  divisor,
	output logic                             done,
	output logic [cvr_pkg::DIVD_W-1:0]       quo,
	output logic [cvr_pkg::DIVS_W-1:0]       rem
);
	localparam int CW = $clog2(cvr_pkg::DIVD_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CW-1:0]               cnt_q;
	logic [cvr_pkg::DIVD_W-1:0]  num_q;
	logic [cvr_pkg::DIVS_W-1:0]  rem_q;
	logic [cvr_pkg::DIVS_W-1:0]  dvs_q;
	logic [cvr_pkg::DIVS_W:0]    trial;
	logic [cvr_pkg::DIVS_W:0]    diff;
	logic                        fits;

	assign trial = {rem_q, num_q[cvr_pkg::DIVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(cvr_pkg::DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[cvr_pkg::DIVD_W-2:0], fits};
			rem_q <= fits ? diff[cvr_pkg::DIVS_W-1:0] : trial[cvr_pkg::DIVS_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = num_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

>>> sv/cvr_dp.sv
// datapath: track store, ramp state, tap fetch, cubic and gain arithmetic
`default_nettype none
module cvr_dp #(
	parameter int TRACK_DEPTH = cvr_pkg::TRACK_DEPTH_DEF,
	parameter int MAX_BLOCK   = cvr_pkg::MAX_BLOCK_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire cvr_pkg::cmd_t              cmd,
	output cvr_pkg::sts_t                   sts,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [cvr_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic [1:0]                 opcode,
	input  wire logic [15:0]                frame_index,
	input  wire logic signed [15:0]         left_in,
	input  wire logic signed [15:0]         right_in,
	input  wire logic signed [39:0]         start_position,
	input  wire logic signed [23:0]         start_pitch,
	input  wire logic signed [23:0]         target_pitch,
	input  wire logic [16:0]                start_volume,
	input  wire logic [16:0]                end_volume,
	input  wire logic [12:0]                frame_count,
	input  wire logic                       out_ready,
	output logic                            out_valid,
	output logic signed [15:0]              left_out,
	output logic signed [15:0]              right_out,
	output logic signed [39:0]              end_position,
	output logic                            last_frame
);
	localparam int AW = $clog2(TRACK_DEPTH);
	localparam logic [24:0] DEPTH_U = 25'(TRACK_DEPTH);
	localparam logic signed [25:0] DEPTH_S = 26'(TRACK_DEPTH);
	localparam logic [16:0] MAXB = 17'(MAX_BLOCK);

	// configuration
	logic [cvr_pkg::RATE_W-1:0]   rate_q;
	logic [cvr_pkg::FRAMES_W-1:0] tf_q;

	// block state
	logic signed [39:0] pos_q;
	logic signed [31:0] pitch_q;
	logic signed [31:0] pstep_q;
	logic signed [29:0] gain_q;
	logic signed [29:0] gstep_q;
	logic [12:0]        frames_q;

	// start item scratch
	logic        pnum_neg_q;
	logic [31:0] pnum_mag_q;
	logic        gnum_neg_q;
	logic [31:0] gnum_mag_q;
	logic [12:0] cnt_q;

	// tick scratch
	logic signed [24:0] first_q;
	logic signed [27:0] step_q;
	logic signed [15:0] yl_q [4];
	logic signed [15:0] yr_q [4];
	logic signed [37:0] accl_q;
	logic signed [37:0] accr_q;
	logic signed [55:0] prodl_q;
	logic signed [55:0] prodr_q;

	// store
	logic [31:0]   mem [TRACK_DEPTH];
	logic [31:0]   rdata_q;
	logic          rvalid_q;

	// output
	logic               out_valid_q;
	logic signed [15:0] left_q;
	logic signed [15:0] right_q;
	logic signed [39:0] endpos_q;
	logic               last_q;

	// start item values
	logic [12:0]        n_sat;
	logic signed [24:0] pdiff;
	logic signed [31:0] pnum;
	logic signed [17:0] gdiff;
	logic signed [29:0] gnum;

	assign n_sat = (17'(frame_count) > MAXB) ? MAXB[12:0] : frame_count;
	assign pdiff = {target_pitch[23], target_pitch} - {start_pitch[23], start_pitch};
	assign pnum  = {pdiff, 7'b0};
	assign gdiff = $signed({1'b0, end_volume}) - $signed({1'b0, start_volume});
	assign gnum  = {gdiff, 12'b0};

	// first tap before wrapping
	logic signed [24:0] first_c;
	logic [24:0]        first_mag;
	assign first_c   = $signed({pos_q[39], pos_q[39:16]}) - 25'sd1;
	assign first_mag = first_c[24] ? 25'(-first_c) : first_c;

	// divider
	logic [31:0] div_dvd;
	logic [16:0] div_dvs;
	logic        div_done;
	logic [31:0] div_quo;
	logic [16:0] div_rem;

	always_comb begin
		case (cmd.div_sel)
			cvr_pkg::DIV_PITCH: begin
				div_dvd = pnum_mag_q;
				div_dvs = {4'b0, cnt_q};
			end
			cvr_pkg::DIV_GAIN: begin
				div_dvd = gnum_mag_q;
				div_dvs = {4'b0, cnt_q};
			end
			cvr_pkg::DIV_MOD: begin
				div_dvd = {7'b0, first_mag};
				div_dvs = tf_q;
			end
			default: begin
				div_dvd = '0;
				div_dvs = tf_q;
			end
		endcase
	end

	cvr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	logic signed [24:0] rem_s;
	assign rem_s = $signed({8'b0, div_rem});

	// tap address
	logic signed [25:0] tap_t;
	logic               tap_ok;
	assign tap_t  = $signed({first_q[24], first_q}) + $signed({24'b0, cmd.rd_tap});
	assign tap_ok = !tap_t[25] && (tap_t < $signed({9'b0, tf_q})) && (tap_t < DEPTH_S);

	// write address
	logic [24:0] widx;
	assign widx = 25'(frame_index);

	always_ff @(posedge clk) begin
		if (cmd.load && opcode == cvr_pkg::OP_WRITE && widx < DEPTH_U)
			mem[widx[AW-1:0]] <= {right_in, left_in};
		if (cmd.rd_en)
			rdata_q <= mem[tap_t[AW-1:0]];
	end

	// cubic coefficients
	logic signed [18:0] a0l, a0r, a2l, a2r;
	logic signed [19:0] a1l, a1r;
	assign a0l = 19'(yl_q[3]) - 19'(yl_q[2]) - 19'(yl_q[0]) + 19'(yl_q[1]);
	assign a0r = 19'(yr_q[3]) - 19'(yr_q[2]) - 19'(yr_q[0]) + 19'(yr_q[1]);
	assign a1l = 20'(yl_q[0]) - 20'(yl_q[1]) - 20'(a0l);
	assign a1r = 20'(yr_q[0]) - 20'(yr_q[1]) - 20'(a0r);
	assign a2l = 19'(yl_q[2]) - 19'(yl_q[0]);
	assign a2r = 19'(yr_q[2]) - 19'(yr_q[0]);

	logic signed [17:0] mu_s;
	logic signed [17:0] vol_s;
	logic signed [17:0] opb;
	logic signed [37:0] opal, opar;
	logic signed [55:0] pl, pr;
	assign mu_s  = $signed({2'b0, pos_q[15:0]});
	assign vol_s = gain_q[29:12];
	assign opb   = (cmd.mac_op == cvr_pkg::MAC_VOL) ? vol_s : mu_s;
	assign opal  = (cmd.mac_op == cvr_pkg::MAC_C1) ? 38'(a0l) : accl_q;
	assign opar  = (cmd.mac_op == cvr_pkg::MAC_C1) ? 38'(a0r) : accr_q;
	assign pl    = 56'(opal) * 56'(opb);
	assign pr    = 56'(opar) * 56'(opb);

	// position step
	logic signed [50:0] pstep_m;
	assign pstep_m = 51'($signed({1'b0, rate_q})) * 51'(pitch_q);

	function automatic logic signed [15:0] sat16(input logic signed [55:0] p);
		logic signed [56:0] adj;
		logic signed [24:0] t;
		adj = 57'(p) + (p[55] ? 57'sh0_FFFF_FFFF : 57'sd0);
		t   = adj[56:32];
		if (t > 25'sd32767)
			sat16 = 16'sh7FFF;
		else if (t < -25'sd32768)
			sat16 = 16'sh8000;
		else
			sat16 = t[15:0];
	endfunction

	logic signed [39:0] pos_next;
	assign pos_next = pos_q + 40'(step_q);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q      <= cvr_pkg::RATE_RESET;
			tf_q        <= '0;
			pos_q       <= '0;
			pitch_q     <= '0;
			pstep_q     <= '0;
			gain_q      <= '0;
			gstep_q     <= '0;
			frames_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cvr_pkg::REG_RATE_RATIO:   rate_q <= cfg_data;
					cvr_pkg::REG_TRACK_FRAMES: tf_q   <= cfg_data[cvr_pkg::FRAMES_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load && opcode == cvr_pkg::OP_START) begin
				pos_q    <= start_position;
				pitch_q  <= {start_pitch[23], start_pitch, 7'b0};
				gain_q   <= {1'b0, start_volume, 12'b0};
				pstep_q  <= '0;
				gstep_q  <= '0;
				frames_q <= n_sat;
			end
			if (cmd.div_cap && cmd.div_sel == cvr_pkg::DIV_PITCH)
				pstep_q <= pnum_neg_q ? 32'(-div_quo) : div_quo;
			if (cmd.div_cap && cmd.div_sel == cvr_pkg::DIV_GAIN)
				gstep_q <= gnum_neg_q ? 30'(-div_quo) : div_quo[29:0];
			if (cmd.out_load) begin
				pos_q <= pos_next;
				if (frames_q != '0) begin
					gain_q   <= gain_q + gstep_q;
					pitch_q  <= pitch_q + pstep_q;
					frames_q <= frames_q - 1'b1;
				end
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// scratch and payload registers
	always_ff @(posedge clk) begin
		if (cmd.load && opcode == cvr_pkg::OP_START) begin
			pnum_neg_q <= pnum[31];
			pnum_mag_q <= pnum[31] ? 32'(-pnum) : pnum;
			gnum_neg_q <= gnum[29];
			gnum_mag_q <= 32'(gnum[29] ? 30'(-gnum) : gnum);
			cnt_q      <= n_sat;
		end
		if (cmd.first_cap)
			first_q <= first_c;
		if (cmd.div_cap && cmd.div_sel == cvr_pkg::DIV_MOD)
			first_q <= first_c[24] ? 25'(-rem_s) : rem_s;
		if (cmd.rd_en)
			rvalid_q <= tap_ok;
		if (cmd.tap_cap) begin
			yl_q[cmd.cap_idx] <= rvalid_q ? rdata_q[15:0] : 16'sd0;
			yr_q[cmd.cap_idx] <= rvalid_q ? rdata_q[31:16] : 16'sd0;
		end
		case (cmd.mac_op)
			cvr_pkg::MAC_C1: begin
				accl_q <= pl[37:0] + {{2{a1l[19]}}, a1l, 16'b0};
				accr_q <= pr[37:0] + {{2{a1r[19]}}, a1r, 16'b0};
				step_q <= pstep_m[50:23];
			end
			cvr_pkg::MAC_C2: begin
				accl_q <= pl[53:16] + {{3{a2l[18]}}, a2l, 16'b0};
				accr_q <= pr[53:16] + {{3{a2r[18]}}, a2r, 16'b0};
			end
			cvr_pkg::MAC_C3: begin
				accl_q <= pl[53:16] + {{6{yl_q[1][15]}}, yl_q[1], 16'b0};
				accr_q <= pr[53:16] + {{6{yr_q[1][15]}}, yr_q[1], 16'b0};
			end
			cvr_pkg::MAC_VOL: begin
				prodl_q <= pl;
				prodr_q <= pr;
			end
			default: ;
		endcase
		if (cmd.out_load) begin
			left_q   <= sat16(prodl_q);
			right_q  <= sat16(prodr_q);
			endpos_q <= pos_next;
			last_q   <= (frames_q == 13'd1);
		end
	end

	assign sts.div_done = div_done;
	assign sts.mod_skip = (tf_q == '0) ||
		(!first_c[24] && (first_c < $signed({8'b0, tf_q})));
	assign sts.cnt_zero = (n_sat == '0);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign left_out     = left_q;
	assign right_out    = right_q;
	assign end_position = endpos_q;
	assign last_frame   = last_q;
endmodule
`default_nettype wire

>>> sv/cvr_ctrl.sv
// controller: sequences start divides, tap reads, cubic steps and output load
`default_nettype none
module cvr_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic [1:0]     opcode,
	input  wire cvr_pkg::sts_t  sts,
	output logic                in_ready,
	output cvr_pkg::cmd_t       cmd
);
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_PDIV  = 5'd1;
	localparam logic [4:0] S_PWAIT = 5'd2;
	localparam logic [4:0] S_GDIV  = 5'd3;
	localparam logic [4:0] S_GWAIT = 5'd4;
	localparam logic [4:0] S_MOD   = 5'd5;
	localparam logic [4:0] S_MWAIT = 5'd6;
	localparam logic [4:0] S_RD0   = 5'd7;
	localparam logic [4:0] S_RD1   = 5'd8;
	localparam logic [4:0] S_RD2   = 5'd9;
	localparam logic [4:0] S_RD3   = 5'd10;
	localparam logic [4:0] S_RD4   = 5'd11;
	localparam logic [4:0] S_C1    = 5'd12;
	localparam logic [4:0] S_C2    = 5'd13;
	localparam logic [4:0] S_C3    = 5'd14;
	localparam logic [4:0] S_C4    = 5'd15;
	localparam logic [4:0] S_OUT   = 5'd16;

	logic [4:0] state_q;
	logic [4:0] state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) begin
					case (opcode)
						cvr_pkg::OP_START: state_d = sts.cnt_zero ? S_IDLE : S_PDIV;
						cvr_pkg::OP_TICK:  state_d = S_MOD;
						default:           state_d = S_IDLE;
					endcase
				end
			end
			S_PDIV: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = cvr_pkg::DIV_PITCH;
				state_d     = S_PWAIT;
			end
			S_PWAIT: begin
				cmd.div_sel = cvr_pkg::DIV_PITCH;
				cmd.div_cap = sts.div_done;
				if (sts.div_done)
					state_d = S_GDIV;
			end
			S_GDIV: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = cvr_pkg::DIV_GAIN;
				state_d     = S_GWAIT;
			end
			S_GWAIT: begin
				cmd.div_sel = cvr_pkg::DIV_GAIN;
				cmd.div_cap = sts.div_done;
				if (sts.div_done)
					state_d = S_IDLE;
			end
			S_MOD: begin
				cmd.div_sel = cvr_pkg::DIV_MOD;
				if (sts.mod_skip) begin
					cmd.first_cap = 1'b1;
					state_d       = S_RD0;
				end else begin
					cmd.div_go = 1'b1;
					state_d    = S_MWAIT;
				end
			end
			S_MWAIT: begin
				cmd.div_sel = cvr_pkg::DIV_MOD;
				cmd.div_cap = sts.div_done;
				if (sts.div_done)
					state_d = S_RD0;
			end
			S_RD0: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_tap = 2'd0;
				state_d    = S_RD1;
			end
			S_RD1: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_tap  = 2'd1;
				cmd.tap_cap = 1'b1;
				cmd.cap_idx = 2'd0;
				state_d     = S_RD2;
			end
			S_RD2: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_tap  = 2'd2;
				cmd.tap_cap = 1'b1;
				cmd.cap_idx = 2'd1;
				state_d     = S_RD3;
			end
			S_RD3: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_tap  = 2'd3;
				cmd.tap_cap = 1'b1;
				cmd.cap_idx = 2'd2;
				state_d     = S_RD4;
			end
			S_RD4: begin
				cmd.tap_cap = 1'b1;
				cmd.cap_idx = 2'd3;
				state_d     = S_C1;
			end
			S_C1: begin
				cmd.mac_op = cvr_pkg::MAC_C1;
				state_d    = S_C2;
			end
			S_C2: begin
				cmd.mac_op = cvr_pkg::MAC_C2;
				state_d    = S_C3;
			end
			S_C3: begin
				cmd.mac_op = cvr_pkg::MAC_C3;
				state_d    = S_C4;
			end
			S_C4: begin
				cmd.mac_op = cvr_pkg::MAC_VOL;
				state_d    = S_OUT;
			end
			S_OUT: begin
				cmd.out_load = sts.out_free;
				if (sts.out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end
endmodule
`default_nettype wire

>>> sv/cubic_varispeed_resampler.sv
// top level of the cubic varispeed resampler
`default_nettype none
// Stereo varispeed player over a stored track of 16-bit frames. A write item
// stores one frame (the block is ready again at the next edge, even while a
// result waits). A start item loads position, pitch and gain, then runs the
// shared one-bit-per-cycle divider twice for the pitch and gain ramps; with a
// zero frame count it skips both divides. A tick reads its taps directly when
// the first tap already lies inside the track; otherwise the tap index is
// wrapped through the same divider first. The tick time is set by the
// single store read port (four taps, one per cycle) and the Horner chain of
// the cubic, one multiply step per cycle on each channel. One result may wait
// in the output register while the next item is taken. Configuration is taken
// any time the block is idle; the track store has no reset and must be
// written before it is read.
module cubic_varispeed_resampler #(
	parameter int TRACK_DEPTH = cvr_pkg::TRACK_DEPTH_DEF,
	parameter int MAX_BLOCK   = cvr_pkg::MAX_BLOCK_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// configuration writes
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [cvr_pkg::CFG_W-1:0]  cfg_data,
	// input item
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [1:0]                 opcode,
	input  wire logic [15:0]                frame_index,
	input  wire logic signed [15:0]         left_in,
	input  wire logic signed [15:0]         right_in,
	input  wire logic signed [39:0]         start_position,
	input  wire logic signed [23:0]         start_pitch,
	input  wire logic signed [23:0]         target_pitch,
	input  wire logic [16:0]                start_volume,
	input  wire logic [16:0]                end_volume,
	input  wire logic [12:0]                frame_count,
	// result item
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [15:0]              left_out,
	output logic signed [15:0]              right_out,
	output logic signed [39:0]              end_position,
	output logic                            last_frame
);
	// commands down to the datapath, status back to the controller
	cvr_pkg::cmd_t cmd;
	cvr_pkg::sts_t sts;

	cvr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// store, ramps, divider and the two multiply lanes
	cvr_dp #(
		.TRACK_DEPTH (TRACK_DEPTH),
		.MAX_BLOCK   (MAX_BLOCK)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.opcode         (opcode),
		.frame_index    (frame_index),
		.left_in        (left_in),
		.right_in       (right_in),
		.start_position (start_position),
		.start_pitch    (start_pitch),
		.target_pitch   (target_pitch),
		.start_volume   (start_volume),
		.end_volume     (end_volume),
		.frame_count    (frame_count),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.left_out       (left_out),
		.right_out      (right_out),
		.end_position   (end_position),
		.last_frame     (last_frame)
	);
endmodule
`default_nettype wire

>>> sv/cvr_checker.sv
// port-level checker for the cubic varispeed resampler, bound to the top level
`default_nettype none
`include "cubic_varispeed_resampler_macros.svh"
module cvr_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       cfg_we,
	input wire logic                       cfg_index,
	input wire logic [cvr_pkg::CFG_W-1:0]  cfg_data,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic [1:0]                 opcode,
	input wire logic [15:0]                frame_index,
	input wire logic signed [15:0]         left_in,
	input wire logic signed [15:0]         right_in,
	input wire logic signed [39:0]         start_position,
	input wire logic signed [23:0]         start_pitch,
	input wire logic signed [23:0]         target_pitch,
	input wire logic [16:0]                start_volume,
	input wire logic [16:0]                end_volume,
	input wire logic [12:0]                frame_count,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic signed [15:0]         left_out,
	input wire logic signed [15:0]         right_out,
	input wire logic signed [39:0]         end_position,
	input wire logic                       last_frame
);
	// a waiting result holds
	`CVR_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(left_out) && $stable(right_out) && $stable(end_position),
		"result changed while stalled")
	// a tick transfer keeps the block busy next cycle
	`CVR_ASSERT_NXT(a_tick_busy, in_valid && in_ready && opcode == cvr_pkg::OP_TICK,
		!in_ready, "ready right after a tick transfer")
	// a frame write leaves the block ready again the next cycle
	`CVR_ASSERT_NXT(a_write_fast, in_valid && in_ready && opcode == cvr_pkg::OP_WRITE,
		in_ready, "not ready after a frame write")
	// a new result only comes out of tick work
	`CVR_ASSERT_IMP(a_out_from_tick, $rose(out_valid), !$past(in_ready),
		"result appeared while idle")
endmodule

bind cubic_varispeed_resampler cvr_checker u_cvr_checker (.*);
`default_nettype wire
